@@ hdl/frm_pkg.sv @@
package frm_pkg;

  localparam int RATE_W     = 24;
  localparam int INTERVAL_W = 32;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int TICKS_W    = 40;
  localparam int FRAMES_W   = 32;
  localparam int AGE_W      = 33;
  localparam int PROD_W     = FRAMES_W + CFG_W;

  localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS = 4'd1;

  localparam logic [CFG_W-1:0] TICK_RATE_RST  = 32'd1000000;
  localparam logic [CFG_W-1:0] HOLD_TICKS_RST = 32'd3000000;

  typedef logic [RATE_W-1:0]     rate_t;
  typedef logic [INTERVAL_W-1:0] interval_t;
  typedef logic [CFG_W-1:0]      cfg_word_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

  typedef struct packed {
    logic take_in;
    logic accum;
    logic mul;
    logic avg_load;
    logic avg_save;
    logic inst_load;
    logic update;
    logic emit;
  } frm_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic latch;
    logic div_done;
    logic out_free;
  } frm_sts_t;

endpackage

@@ hdl/frm_ifs.sv @@
interface frm_frame_if;
  logic               valid;
  logic               ready;
  frm_pkg::interval_t frame_interval;

  modport source (output valid, output frame_interval, input ready);
  modport sink   (input valid, input frame_interval, output ready);
endinterface

interface frm_rate_if;
  logic           valid;
  logic           ready;
  frm_pkg::rate_t instant_rate;
  frm_pkg::rate_t average_rate;
  logic           average_valid;
  frm_pkg::rate_t high_rate;
  frm_pkg::rate_t low_rate;

  modport source (output valid, output instant_rate, output average_rate,
                  output average_valid, output high_rate, output low_rate,
                  input ready);
  modport sink   (input valid, input instant_rate, input average_rate,
                  input average_valid, input high_rate, input low_rate,
                  output ready);
endinterface

interface frm_cfg_if;
  logic               valid;
  logic               ready;
  frm_pkg::cfg_idx_t  index;
  frm_pkg::cfg_word_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/frame_rate_meter_peak_hold.sv @@
// channel  dir  handshake      payload
// frame    in   valid/ready    frame_interval[31:0]
// rate     out  valid/ready    instant_rate, average_rate, average_valid,
//                              high_rate, low_rate
// cfg      in   valid/ready    index[3:0], data[31:0] (0 tick_rate, 1 hold_ticks)
//
// one frame at a time: when the window closes, the average is divided before the instant
// rate; each division is 24 steps of the shared divider
// the next frame can be taken in the cycle after the result is loaded
// rst is synchronous and restores tick_rate and hold_ticks to their defaults
// the result waits in an output register; a stalled rate channel holds the
// next frame's result in the emit state, and frame.ready drops meanwhile
module frame_rate_meter_peak_hold #(
  parameter int RATE_FRAC_BITS = 8
) (
  input logic        clk,
  input logic        rst,
  frm_frame_if.sink  frame,
  frm_rate_if.source rate,
  frm_cfg_if.sink    cfg
);
  import frm_pkg::*;

  frm_cmd_t cmd;
  frm_sts_t sts;

  frm_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  frm_dp #(.FRAC_BITS(RATE_FRAC_BITS)) u_dp (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .sts   (sts),
    .frame (frame),
    .rate  (rate),
    .cfg   (cfg)
  );

endmodule

@@ hdl/frm_div.sv @@
module frm_div #(
  parameter int FRAC_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [frm_pkg::PROD_W-1:0]         num,
  input  logic [frm_pkg::TICKS_W-1:0]        den,
  output logic                               done,
  output frm_pkg::rate_t                     quot
);
  import frm_pkg::*;

  localparam int NW    = PROD_W + RATE_W;
  localparam int CNT_W = $clog2(RATE_W + 1);

  logic [NW-1:0]      nshift;
  logic               sat_load;
  logic [TICKS_W-1:0] den_r;
  logic [TICKS_W-1:0] rem;
  logic [RATE_W-1:0]  low;
  logic [RATE_W-1:0]  q;
  logic               sat;
  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [TICKS_W:0]   trial;
  logic [TICKS_W:0]   diff;
  logic               ge;

  // numerator scaled by the fraction bits, zero padded above
  assign nshift   = {{RATE_W{1'b0}}, num} << FRAC_BITS;
  // quotient would need more than RATE_W bits, or the divisor is zero
  assign sat_load = (den == '0) ||
                    (nshift[NW-1:RATE_W] >= {{(PROD_W-TICKS_W){1'b0}}, den});

  assign trial = {rem, low[RATE_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(RATE_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      sat   <= sat_load;
      rem   <= nshift[RATE_W +: TICKS_W];
      low   <= nshift[RATE_W-1:0];
      q     <= '0;
    end else if (busy) begin
      rem <= ge ? diff[TICKS_W-1:0] : trial[TICKS_W-1:0];
      low <= {low[RATE_W-2:0], 1'b0};
      q   <= {q[RATE_W-2:0], ge};
    end
  end

  assign quot = sat ? '1 : q;

endmodule

@@ hdl/frm_ctrl.sv @@
module frm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  frm_pkg::frm_sts_t sts,
  output frm_pkg::frm_cmd_t cmd
);
  import frm_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_ACCUM     = 11'b000_0000_0010,
    S_CHECK     = 11'b000_0000_0100,
    S_MUL       = 11'b000_0000_1000,
    S_AVG_LOAD  = 11'b000_0001_0000,
    S_AVG_DIV   = 11'b000_0010_0000,
    S_AVG_SAVE  = 11'b000_0100_0000,
    S_INST_LOAD = 11'b000_1000_0000,
    S_INST_DIV  = 11'b001_0000_0000,
    S_UPDATE    = 11'b010_0000_0000,
    S_EMIT      = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.take_in = 1'b1;
        if (sts.in_valid) state_next = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = sts.latch ? S_MUL : S_INST_LOAD;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_AVG_LOAD;
      end
      S_AVG_LOAD: begin
        cmd.avg_load = 1'b1;
        state_next   = S_AVG_DIV;
      end
      S_AVG_DIV: begin
        if (sts.div_done) state_next = S_AVG_SAVE;
      end
      S_AVG_SAVE: begin
        cmd.avg_save = 1'b1;
        state_next   = S_INST_LOAD;
      end
      S_INST_LOAD: begin
        cmd.inst_load = 1'b1;
        state_next    = S_INST_DIV;
      end
      S_INST_DIV: begin
        if (sts.div_done) state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/frm_dp.sv @@
module frm_dp #(
  parameter int FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  frm_pkg::frm_cmd_t cmd,
  output frm_pkg::frm_sts_t sts,
  frm_frame_if.sink         frame,
  frm_rate_if.source        rate,
  frm_cfg_if.sink           cfg
);
  import frm_pkg::*;

  cfg_word_t           tick_rate;
  cfg_word_t           hold_ticks;
  interval_t           interval;
  logic [TICKS_W-1:0]  window_ticks;
  logic [FRAMES_W-1:0] window_frames;
  logic [PROD_W-1:0]   prod;
  rate_t               average_hold;
  logic                average_seen;
  rate_t               high_hold;
  logic [AGE_W-1:0]    high_age;
  rate_t               low_hold;
  logic [AGE_W-1:0]    low_age;
  rate_t               inst_rate;
  logic                out_valid;

  logic                div_start;
  logic [PROD_W-1:0]   div_num;
  logic [TICKS_W-1:0]  div_den;
  logic                div_done;
  rate_t               quot;

  logic [TICKS_W-1:0]  ticks_sum;
  logic [AGE_W:0]      high_sum;
  logic [AGE_W:0]      low_sum;
  logic                high_take;
  logic                low_take;

  assign frame.ready = cmd.take_in;
  assign cfg.ready   = 1'b1;

  assign sts.in_valid = frame.valid;
  assign sts.latch    = window_ticks >= {{(TICKS_W-CFG_W){1'b0}}, tick_rate};
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid || rate.ready;

  assign div_start = cmd.avg_load || cmd.inst_load;
  assign div_num   = cmd.avg_load ? prod : {{(PROD_W-CFG_W){1'b0}}, tick_rate};
  assign div_den   = cmd.avg_load ? window_ticks
                                  : {{(TICKS_W-INTERVAL_W){1'b0}}, interval};

  frm_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  assign ticks_sum = window_ticks + {{(TICKS_W-INTERVAL_W){1'b0}}, interval};
  assign high_sum  = {1'b0, high_age} + {{(AGE_W+1-INTERVAL_W){1'b0}}, interval};
  assign low_sum   = {1'b0, low_age} + {{(AGE_W+1-INTERVAL_W){1'b0}}, interval};
  assign high_take = (quot > high_hold) ||
                     (high_age > {{(AGE_W-CFG_W){1'b0}}, hold_ticks});
  assign low_take  = (quot < low_hold) ||
                     (low_age > {{(AGE_W-CFG_W){1'b0}}, hold_ticks});

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate  <= TICK_RATE_RST;
      hold_ticks <= HOLD_TICKS_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_TICK_RATE:  tick_rate  <= cfg.data;
        REG_HOLD_TICKS: hold_ticks <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks  <= '0;
      window_frames <= '0;
      average_hold  <= '0;
      average_seen  <= 1'b0;
    end else if (cmd.accum) begin
      window_ticks <= ticks_sum;
      if (window_frames != '1) window_frames <= window_frames + 1'b1;
    end else if (cmd.avg_save) begin
      average_hold  <= quot;
      average_seen  <= 1'b1;
      window_ticks  <= '0;
      window_frames <= '0;
    end
  end

  // high and low holds, each aged in ticks and saturating
  always_ff @(posedge clk) begin
    if (rst) begin
      high_hold <= '0;
      high_age  <= '0;
      low_hold  <= '0;
      low_age   <= '0;
    end else if (cmd.update) begin
      if (high_take) begin
        high_hold <= quot;
        high_age  <= '0;
      end else begin
        high_age <= high_sum[AGE_W] ? '1 : high_sum[AGE_W-1:0];
      end
      if (low_take) begin
        low_hold <= quot;
        low_age  <= '0;
      end else begin
        low_age <= low_sum[AGE_W] ? '1 : low_sum[AGE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid && cmd.take_in) interval <= frame.frame_interval;
    if (cmd.mul) prod <= {{(PROD_W-FRAMES_W){1'b0}}, window_frames} *
                         {{(PROD_W-CFG_W){1'b0}}, tick_rate};
    if (cmd.update) inst_rate <= quot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (rate.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rate.instant_rate  <= inst_rate;
      rate.average_rate  <= average_hold;
      rate.average_valid <= average_seen;
      rate.high_rate     <= high_hold;
      rate.low_rate      <= low_hold;
    end
  end

  assign rate.valid = out_valid;

endmodule

@@ hdl/frm_chk.sv @@
module frm_chk (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input frm_pkg::rate_t instant_rate,
  input frm_pkg::rate_t average_rate,
  input logic           average_valid,
  input frm_pkg::rate_t high_rate,
  input frm_pkg::rate_t low_rate
);
  import frm_pkg::*;

  logic avg_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_seen <= 1'b0;
    end else if (out_valid && out_ready && average_valid) begin
      avg_seen <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_one_frame: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second frame taken while one is in work");

  a_avg_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && avg_seen |-> average_valid)
    else $error("average flag fell after a latch");

  a_avg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !average_valid |-> average_rate == '0)
    else $error("average shown before any latch");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (low_rate <= instant_rate) && (instant_rate <= high_rate))
    else $error("instant rate outside the held range");

endmodule

bind frame_rate_meter_peak_hold frm_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (frame.valid),
  .in_ready      (frame.ready),
  .out_valid     (rate.valid),
  .out_ready     (rate.ready),
  .instant_rate  (rate.instant_rate),
  .average_rate  (rate.average_rate),
  .average_valid (rate.average_valid),
  .high_rate     (rate.high_rate),
  .low_rate      (rate.low_rate)
);

@@ test/frame_rate_meter_peak_hold_tb.sv @@
`timescale 1ns / 100ps

module frame_rate_meter_peak_hold_tb;
  import frm_pkg::*;

  localparam int FRAC = 8;
  localparam logic [63:0] RATE_MAX = (64'd1 << RATE_W) - 1;
  localparam logic [AGE_W-1:0] AGE_MAX = '1;
  localparam cfg_idx_t REG_FIRST_UNUSED = REG_HOLD_TICKS + 1'b1;
  localparam cfg_idx_t REG_LAST_INDEX = '1;
  localparam int SETTLE_CYCLES = 80;

  typedef struct packed {
    rate_t instant;
    rate_t average;
    logic  avg_valid;
    rate_t high;
    rate_t low;
  } rate_result_t;

  logic clk = 1'b0;
  logic rst;

  frm_frame_if frame_bus ();
  frm_rate_if  rate_bus ();
  frm_cfg_if   cfg_bus ();

  frame_rate_meter_peak_hold #(
    .RATE_FRAC_BITS(FRAC)
  ) i_dut (
    .clk  (clk),
    .rst  (rst),
    .frame(frame_bus),
    .rate (rate_bus),
    .cfg  (cfg_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // meter model state
  cfg_word_t           tick_rate_q = TICK_RATE_RST;
  cfg_word_t           hold_q      = HOLD_TICKS_RST;
  logic [TICKS_W-1:0]  win_ticks   = '0;
  logic [FRAMES_W-1:0] win_frames  = '0;
  rate_t               avg_hold    = '0;
  logic                avg_seen    = 1'b0;
  rate_t               high_hold   = '0;
  logic [AGE_W-1:0]    high_age    = '0;
  rate_t               low_hold    = '0;
  logic [AGE_W-1:0]    low_age     = '0;

  rate_result_t expected_rates[$];
  int           mismatches    = 0;
  int           src_idle_pct  = 0;
  int           sink_idle_pct = 0;

  // floor(num * 2^FRAC / den) in 24 bits, saturating; zero divisor saturates
  function automatic rate_t q_div(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    logic [63:0] full;
    if (den == 0) return '1;
    quo = num / den;
    rem = num % den;
    if (quo > (RATE_MAX >> FRAC)) return '1;
    full = (quo << FRAC) + ((rem << FRAC) / den);
    if (full > RATE_MAX) return '1;
    return full[RATE_W-1:0];
  endfunction

  function automatic logic [AGE_W-1:0] age_sum(logic [AGE_W-1:0] age, interval_t iv);
    logic [AGE_W+1:0] s;
    s = (AGE_W+2)'(age) + (AGE_W+2)'(iv);
    return (s > AGE_MAX) ? AGE_MAX : s[AGE_W-1:0];
  endfunction

  function automatic rate_result_t predict_rates(interval_t iv);
    rate_result_t res;
    rate_t        inst;
    win_ticks = win_ticks + TICKS_W'(iv);
    if (win_frames != '1) win_frames = win_frames + 1'b1;
    if (win_ticks >= tick_rate_q) begin
      avg_hold   = q_div(64'(win_frames) * 64'(tick_rate_q), 64'(win_ticks));
      avg_seen   = 1'b1;
      win_ticks  = '0;
      win_frames = '0;
    end
    inst = q_div(64'(tick_rate_q), 64'(iv));
    if (inst > high_hold || high_age > AGE_W'(hold_q)) begin
      high_hold = inst;
      high_age  = '0;
    end else begin
      high_age = age_sum(high_age, iv);
    end
    if (inst < low_hold || low_age > AGE_W'(hold_q)) begin
      low_hold = inst;
      low_age  = '0;
    end else begin
      low_age = age_sum(low_age, iv);
    end
    res.instant   = inst;
    res.average   = avg_hold;
    res.avg_valid = avg_seen;
    res.high      = high_hold;
    res.low       = low_hold;
    return res;
  endfunction

  // valid stays high into the next request unless the sender idles
  task automatic send_frame(interval_t iv);
    while ($urandom_range(99) < src_idle_pct) begin
      frame_bus.valid <= 1'b0;
      @(posedge clk);
    end
    frame_bus.valid          <= 1'b1;
    frame_bus.frame_interval <= iv;
    @(posedge clk);
    while (!frame_bus.ready) @(posedge clk);
    expected_rates.push_back(predict_rates(iv));
  endtask

  task automatic settle();
    frame_bus.valid <= 1'b0;
    while (expected_rates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes both registers plus one index that the block must ignore
  task automatic set_config(cfg_word_t tick, cfg_word_t hold);
    cfg_idx_t  idx [3];
    cfg_word_t val [3];
    idx[0] = REG_TICK_RATE;
    val[0] = tick;
    idx[1] = cfg_idx_t'($urandom_range(REG_LAST_INDEX, REG_FIRST_UNUSED));
    val[1] = $urandom();
    idx[2] = REG_HOLD_TICKS;
    val[2] = hold;
    for (int i = 0; i < 3; i++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx[i];
      cfg_bus.data  <= val[i];
      @(posedge clk);
      while (!cfg_bus.ready) @(posedge clk);
      if (idx[i] == REG_TICK_RATE) tick_rate_q = val[i];
      else if (idx[i] == REG_HOLD_TICKS) hold_q = val[i];
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // defaults straight out of reset; the low hold sits at zero until it ages out
  task automatic test_reset_state();
    interval_t ivs [10];
    ivs = '{32'd0, 32'd1, 32'd16667, 32'd1000000, 32'd1000000, 32'd1000000,
            32'd1000000, 32'd33333, 32'hFFFF_FFFF, 32'h8000_0000};
    foreach (ivs[i]) send_frame(ivs[i]);
    settle();
  endtask

  task automatic test_rate_extremes();
    interval_t ivs [6];
    set_config(32'hFFFF_FFFF, 32'd0);
    ivs = '{32'd1, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_FFFF, 32'd0, 32'h5555_5555};
    foreach (ivs[i]) send_frame(ivs[i]);
    settle();
    set_config(32'd1, 32'hFFFF_FFFF);
    send_frame(32'd1);
    send_frame(32'd3);
    send_frame(32'd0);
    settle();
  endtask

  // every frame closes the window; a zero interval leaves it empty
  task automatic test_zero_tick_rate();
    set_config(32'd0, 32'd5);
    send_frame(32'd0);
    send_frame(32'd7);
    send_frame(32'd0);
    send_frame(32'hFFFF_FFFF);
    send_frame(32'd2);
    settle();
  endtask

  function automatic cfg_word_t pick_tick_rate();
    case ($urandom_range(7))
      0:       return 32'd1;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd0;
      3:       return $urandom_range(1000, 2);
      4:       return $urandom();
      default: return TICK_RATE_RST;
    endcase
  endfunction

  function automatic cfg_word_t pick_hold(cfg_word_t tick);
    case ($urandom_range(5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom();
      default: return tick * $urandom_range(4, 1) / 2;
    endcase
  endfunction

  function automatic interval_t pick_interval();
    interval_t base;
    case ($urandom_range(11))
      0:       return '0;
      1:       return $urandom_range(15);
      2, 3:    return $urandom();
      default: begin
        // paced frames so that windows close and holds move
        base = tick_rate_q / $urandom_range(240, 1);
        return base + $urandom_range(base >> 3) - (base >> 4);
      end
    endcase
  endfunction

  task automatic test_random_traffic(int blocks, int per_block);
    cfg_word_t tick;
    for (int b = 0; b < blocks; b++) begin
      tick = pick_tick_rate();
      set_config(tick, pick_hold(tick));
      repeat (per_block) send_frame(pick_interval());
      settle();
    end
  endtask

  initial begin : rate_monitor
    rate_result_t want;
    rate_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rate_bus.valid && rate_bus.ready) begin
        if (expected_rates.size() == 0) begin
          $error("rate result with no frame outstanding");
          mismatches++;
        end else begin
          want = expected_rates.pop_front();
          if (rate_bus.instant_rate !== want.instant) begin
            $error("instant_rate: expected %h, got %h", want.instant, rate_bus.instant_rate);
            mismatches++;
          end
          if (rate_bus.average_rate !== want.average) begin
            $error("average_rate: expected %h, got %h", want.average, rate_bus.average_rate);
            mismatches++;
          end
          if (rate_bus.average_valid !== want.avg_valid) begin
            $error("average_valid: expected %b, got %b", want.avg_valid,
                   rate_bus.average_valid);
            mismatches++;
          end
          if (rate_bus.high_rate !== want.high) begin
            $error("high_rate: expected %h, got %h", want.high, rate_bus.high_rate);
            mismatches++;
          end
          if (rate_bus.low_rate !== want.low) begin
            $error("low_rate: expected %h, got %h", want.low, rate_bus.low_rate);
            mismatches++;
          end
        end
      end
      rate_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  initial begin
    rst                      <= 1'b1;
    frame_bus.valid          <= 1'b0;
    frame_bus.frame_interval <= '0;
    cfg_bus.valid            <= 1'b0;
    cfg_bus.index            <= REG_TICK_RATE;
    cfg_bus.data             <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct  = 15;
    sink_idle_pct = 46;
    test_reset_state();
    test_rate_extremes();
    test_zero_tick_rate();
    test_random_traffic(4, 100);

    src_idle_pct  = 46;
    sink_idle_pct = 15;
    test_random_traffic(4, 100);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_traffic(4, 100);

    settle();
    if (mismatches == 0) begin
      $display("frame_rate_meter_peak_hold_tb passed");
    end else begin
      $display("frame_rate_meter_peak_hold_tb failed");
    end
    $finish;
  end

  initial begin
    #(4_000_000);
    $display("frame_rate_meter_peak_hold_tb failed");
    $finish;
  end

endmodule
